// File: sv/mnq_pkg.sv
// Shared types and constants of the MIDI note quantize scheduler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package mnq_pkg;

  localparam int MAX_BLOCK  = 4096;
  localparam int OFF_W      = 12;
  localparam int BS_W       = 13;
  localparam int PPQ_W      = 56;
  localparam int PPS_W      = 33;
  localparam int GRID_W     = 37;
  localparam int SR_W       = 18;
  localparam int MSG_W      = 22;
  localparam int DIV_NW     = 58;
  localparam int DIV_DW     = 38;
  localparam int RESULT_CAP = 32;
  localparam int N_W        = 6;
  localparam int OUTQ_DEPTH = 4;
  localparam int GAP_DIV    = 100;

  // Ten milliseconds of samples is sample_rate / 100, formed as a multiply by a
  // scaled reciprocal and a shift. It is exact for every 18-bit sample rate.
  localparam int          GAP_SHIFT = 25;
  localparam logic [18:0] GAP_RECIP = 19'd335545;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;

  localparam logic [1:0] REG_GRID        = 2'd0;
  localparam logic [1:0] REG_VEL_FIXED   = 2'd1;
  localparam logic [1:0] REG_VEL_VALUE   = 2'd2;
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd3;

  typedef struct packed {
    logic [GRID_W-1:0] grid;
    logic              vel_fixed;
    logic [6:0]        vel_value;
    logic [SR_W-1:0]   sample_rate;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [BS_W-1:0]   block_size;
    logic [PPQ_W-1:0]  start_ppq;
    logic [PPS_W-1:0]  pps;
    logic              have_ppq;
    logic [OFF_W-1:0]  offset;
    logic [7:0]        status;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic              is_on;
    logic              is_off;
  } item_t;

  typedef struct packed {
    logic [7:0]       status;
    logic [6:0]       note;
    logic [6:0]       vel;
    logic [OFF_W-1:0] offset;
    logic             dropped;
    logic             last;
  } result_t;

  // A stored message is a note-on when its status is 0x9n with nonzero velocity.
  function automatic logic msg_is_on(input logic [MSG_W-1:0] m);
    return (m[21:18] == ST_NOTE_ON) && (m[6:0] != 7'd0);
  endfunction

endpackage
`default_nettype wire

// File: sv/mnq_div.sv
// Restoring divider, one quotient bit per cycle, shared by the scheduler.
// Depends on mnq_pkg for the operand widths.
`default_nettype none
module mnq_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [mnq_pkg::DIV_NW-1:0] num,
  input  wire [mnq_pkg::DIV_DW-1:0] den,
  output logic                     done,
  output logic [mnq_pkg::DIV_NW-1:0] quo,
  output logic [mnq_pkg::DIV_DW-1:0] rem
);
  import mnq_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              run_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r, rem_r;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, num_r[DIV_NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand shift register; the quotient fills in from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[DIV_NW-2:0], ge};
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: sv/mnq_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on mnq_pkg.
`default_nettype none
module mnq_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_push,
  output logic                       in_full,
  input  wire                        in_op,
  input  wire [mnq_pkg::BS_W-1:0]    in_block_size,
  input  wire [mnq_pkg::PPQ_W-1:0]   in_block_start_ppq,
  input  wire [mnq_pkg::PPS_W-1:0]   in_ppq_per_sample,
  input  wire                        in_have_ppq,
  input  wire [mnq_pkg::OFF_W-1:0]   in_event_offset,
  input  wire [7:0]                  in_status_byte,
  input  wire [6:0]                  in_note_number,
  input  wire [6:0]                  in_velocity,
  input  mnq_pkg::cfg_t              cfg,
  output mnq_pkg::item_t             item,
  output logic                       item_valid,
  input  wire                        item_pop
);
  import mnq_pkg::*;

  item_t      cls;
  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  // Classify the incoming beat, apply the fixed velocity and clamp the block size.
  always_comb begin
    cls.op         = in_op;
    cls.start_ppq  = in_block_start_ppq;
    cls.pps        = in_ppq_per_sample;
    cls.have_ppq   = in_have_ppq;
    cls.offset     = in_event_offset;
    cls.status     = in_status_byte;
    cls.note       = in_note_number;
    cls.is_on      = (in_status_byte[7:4] == ST_NOTE_ON) && (in_velocity != 7'd0);
    cls.is_off     = (in_status_byte[7:4] == ST_NOTE_OFF) ||
                     ((in_status_byte[7:4] == ST_NOTE_ON) && (in_velocity == 7'd0));
    cls.vel        = in_velocity;
    if (cfg.vel_fixed && cls.is_on) begin
      cls.vel = (cfg.vel_value == 7'd0) ? 7'd1 : cfg.vel_value;
    end
    if (in_block_size == '0) begin
      cls.block_size = BS_W'(1);
    end else if (in_block_size > BS_W'(MAX_BLOCK)) begin
      cls.block_size = BS_W'(MAX_BLOCK);
    end else begin
      cls.block_size = in_block_size;
    end
  end

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_pop && item_valid;

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
  end

endmodule
`default_nettype wire

// File: sv/mnq_outq.sv
// Result queue between the back end and the result port.
// Depends on mnq_pkg for the result type and depth.
`default_nettype none
module mnq_outq (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  mnq_pkg::result_t  wdata,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output mnq_pkg::result_t  rdata
);
  import mnq_pkg::*;

  localparam int AW = $clog2(OUTQ_DEPTH);

  result_t     mem_r [OUTQ_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == (AW+1)'(OUTQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + AW'(1);
      if (pop_ok) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// File: sv/mnq_back.sv
// Back end: sequencer that runs block starts, quantizing and note-off holds
// over the pending queue and the placed table. Depends on mnq_pkg, mnq_div.
`default_nettype none
module mnq_back #(
  parameter int PENDING_DEPTH = 32,
  parameter int PLACED_DEPTH  = 16,
  parameter int COUNTER_BITS  = 48
) (
  input  wire               clk,
  input  wire               rst_n,
  input  mnq_pkg::cfg_t     cfg,
  input  mnq_pkg::item_t    item,
  input  wire               item_valid,
  output logic              item_pop,
  output logic              opush,
  output mnq_pkg::result_t  odata,
  input  wire               ofull
);
  import mnq_pkg::*;

  localparam int CB   = COUNTER_BITS;
  localparam int PIW  = $clog2(PENDING_DEPTH);
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);
  localparam int LIW  = $clog2(PLACED_DEPTH);
  localparam int LCW  = $clog2(PLACED_DEPTH + 1);
  localparam int GP_W = SR_W + 19;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_FLUSH = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_DIVP  = 11'b00000010000,
    S_DIV1  = 11'b00000100000,
    S_DIV2  = 11'b00001000000,
    S_QUEUE = 11'b00010000000,
    S_GAPW  = 11'b00100000000,
    S_PSCAN = 11'b01000000000,
    S_LSCAN = 11'b10000000000
  } state_t;

  // Later of two wrapping trigger times.
  function automatic logic [CB-1:0] cmax(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB-1:0] d;
    d = b - a;
    return ((d != '0) && !d[CB-1]) ? b : a;
  endfunction

  state_t state_r, state_nxt;

  logic [CB-1:0]    sc_r, sc_nxt;
  logic [BS_W-1:0]  len_r, len_nxt;
  logic [PPQ_W-1:0] lstart_r, lstart_nxt;
  logic [PPS_W-1:0] lpps_r, lpps_nxt;
  logic             lhave_r, lhave_nxt;

  logic [MSG_W-1:0] pmsg_r [PENDING_DEPTH];
  logic [CB-1:0]    ptrig_r [PENDING_DEPTH];
  logic [PCW-1:0]   pcnt_r, pcnt_nxt;
  logic [3:0]       lch_r [PLACED_DEPTH];
  logic [6:0]       lnote_r [PLACED_DEPTH];
  logic [CB-1:0]    ltrig_r [PLACED_DEPTH];
  logic [LCW-1:0]   lcnt_r, lcnt_nxt;

  logic [PCW-1:0]   pi_r, pi_nxt;
  logic [LCW-1:0]   li_r, li_nxt;
  logic [N_W-1:0]   n_r, n_nxt;

  logic [7:0]       st_r, st_nxt;
  logic [6:0]       note_r, note_nxt;
  logic [6:0]       vel_r, vel_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [PPQ_W:0]   p_r, p_nxt;
  logic [CB-1:0]    trig_r, trig_nxt;
  logic [SR_W-1:0]  gap_r, gap_nxt;
  result_t          held_r, held_nxt;
  logic             hv_r, hv_nxt;

  // Table update requests from the sequencer.
  logic             prm, papp, lrm, lapp;
  logic [PCW-1:0]   prm_idx;
  logic [LCW-1:0]   lrm_idx;
  logic [CB-1:0]    papp_trig, lapp_trig;

  logic             div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den, div_rem;

  logic [OFF_W-1:0] off_c;
  logic             quant;
  logic [CB-1:0]    d, t, natural;
  logic [MSG_W-1:0] m;
  logic [GRID_W-1:0] gp;
  logic [39:0]      target;
  logic [GP_W-1:0]  gap_prod;

  mnq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign quant   = (cfg.grid != '0) && lhave_r && (lpps_r != '0);
  assign natural = sc_r + CB'(off_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    sc_nxt = sc_r;  len_nxt = len_r;  lstart_nxt = lstart_r;
    lpps_nxt = lpps_r;  lhave_nxt = lhave_r;
    pcnt_nxt = pcnt_r;  lcnt_nxt = lcnt_r;
    pi_nxt = pi_r;  li_nxt = li_r;  n_nxt = n_r;
    st_nxt = st_r;  note_nxt = note_r;  vel_nxt = vel_r;  off_nxt = off_r;
    p_nxt = p_r;  trig_nxt = trig_r;  gap_nxt = gap_r;
    held_nxt = held_r;  hv_nxt = hv_r;
    prm = 1'b0;  prm_idx = '0;  papp = 1'b0;  papp_trig = trig_r;
    lrm = 1'b0;  lrm_idx = '0;  lapp = 1'b0;  lapp_trig = '0;
    item_pop = 1'b0;  opush = 1'b0;  odata = held_r;
    div_start = 1'b0;  div_num = '0;  div_den = '0;
    off_c = '0;  d = '0;  t = '0;  m = '0;  gp = '0;  target = '0;
    gap_prod = '0;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (!item.op) begin
            // Block start: advance time, latch song position, clear placed table.
            sc_nxt     = sc_r + CB'(len_r);
            len_nxt    = item.block_size;
            lstart_nxt = item.start_ppq;
            lpps_nxt   = item.pps;
            lhave_nxt  = item.have_ppq;
            lcnt_nxt   = '0;
            pi_nxt     = '0;
            n_nxt      = '0;
            state_nxt  = S_SCAN;
          end else begin
            if (len_r == '0) begin
              off_c = '0;
            end else if ({1'b0, item.offset} >= len_r) begin
              off_c = OFF_W'(len_r - BS_W'(1));
            end else begin
              off_c = item.offset;
            end
            st_nxt   = item.status;
            note_nxt = item.note;
            vel_nxt  = item.vel;
            off_nxt  = off_c;
            if (quant && item.is_on) begin
              state_nxt = S_MUL;
            end else if (quant && item.is_off) begin
              state_nxt = S_GAPW;
            end else begin
              held_nxt  = '{item.status, item.note, item.vel, off_c, 1'b0, 1'b0};
              hv_nxt    = 1'b1;
              state_nxt = S_FLUSH;
            end
          end
        end
      end

      S_SCAN: begin
        // Emit due pending entries, one per cycle while the result queue has room.
        if ((pi_r < pcnt_r) && (n_r < N_W'(RESULT_CAP))) begin
          d = ptrig_r[pi_r[PIW-1:0]] - sc_r;
          m = pmsg_r[pi_r[PIW-1:0]];
          if (d[CB-1] || (d < CB'(len_r))) begin
            if (!hv_r || !ofull) begin
              opush    = hv_r;
              held_nxt = '{m[21:14], m[13:7], m[6:0],
                           d[CB-1] ? '0 : d[OFF_W-1:0], 1'b0, 1'b0};
              hv_nxt   = 1'b1;
              n_nxt    = n_r + N_W'(1);
              prm      = 1'b1;
              prm_idx  = pi_r;
              pcnt_nxt = pcnt_r - PCW'(1);
            end
          end else begin
            pi_nxt = pi_r + PCW'(1);
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        // The final result of the item carries the last flag.
        if (hv_r) begin
          if (!ofull) begin
            opush      = 1'b1;
            odata.last = 1'b1;
            hv_nxt     = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_MUL: begin
        p_nxt     = (PPQ_W+1)'(lstart_r) + (PPQ_W+1)'(45'(off_r) * 45'(lpps_r));
        state_nxt = S_DIVP;
      end

      S_DIVP: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(p_r);
        div_den   = DIV_DW'(cfg.grid);
        state_nxt = S_DIV1;
      end

      S_DIV1: begin
        // Distance to the next grid line, then round it to samples.
        if (div_done) begin
          gp        = (div_rem == '0) ? '0 : (cfg.grid - GRID_W'(div_rem));
          div_start = 1'b1;
          div_num   = DIV_NW'({gp, 1'b0}) + DIV_NW'(lpps_r);
          div_den   = DIV_DW'({lpps_r, 1'b0});
          state_nxt = S_DIV2;
        end
      end

      S_DIV2: begin
        if (div_done) begin
          target = 40'(off_r) + 40'(div_quo[38:0]);
          if (target < 40'(len_r)) begin
            held_nxt  = '{st_r, note_r, vel_r, target[OFF_W-1:0], 1'b0, 1'b0};
            hv_nxt    = 1'b1;
            if (lcnt_r < LCW'(PLACED_DEPTH)) begin
              lapp      = 1'b1;
              lapp_trig = sc_r + CB'(target);
              lcnt_nxt  = lcnt_r + LCW'(1);
            end
            state_nxt = S_FLUSH;
          end else begin
            trig_nxt  = sc_r + CB'(target);
            state_nxt = S_QUEUE;
          end
        end
      end

      S_QUEUE: begin
        if (pcnt_r >= PCW'(PENDING_DEPTH)) begin
          held_nxt = '{st_r, note_r, vel_r, '0, 1'b1, 1'b0};
          hv_nxt   = 1'b1;
        end else begin
          papp     = 1'b1;
          pcnt_nxt = pcnt_r + PCW'(1);
        end
        state_nxt = S_FLUSH;
      end

      S_GAPW: begin
        // Minimum note length of 10 ms in samples.
        gap_prod  = GP_W'(cfg.sample_rate) * GP_W'(GAP_RECIP);
        gap_nxt   = SR_W'(gap_prod[GP_W-1:GAP_SHIFT]);
        pi_nxt    = '0;
        state_nxt = S_PSCAN;
      end

      S_PSCAN: begin
        // Look for the matching note-on among the pending entries.
        if (pi_r < pcnt_r) begin
          m = pmsg_r[pi_r[PIW-1:0]];
          if (msg_is_on(m) && (m[17:14] == st_r[3:0]) && (m[13:7] == note_r)) begin
            trig_nxt  = cmax(natural, ptrig_r[pi_r[PIW-1:0]] + CB'(gap_r));
            state_nxt = S_QUEUE;
          end else begin
            pi_nxt = pi_r + PCW'(1);
          end
        end else begin
          li_nxt    = '0;
          state_nxt = S_LSCAN;
        end
      end

      S_LSCAN: begin
        // Then among the note-ons placed in this block.
        if (li_r < lcnt_r) begin
          if ((lch_r[li_r[LIW-1:0]] == st_r[3:0]) && (lnote_r[li_r[LIW-1:0]] == note_r)) begin
            t = cmax(natural, ltrig_r[li_r[LIW-1:0]] + CB'(gap_r));
            d = t - sc_r;
            lrm      = 1'b1;
            lrm_idx  = li_r;
            lcnt_nxt = lcnt_r - LCW'(1);
            if (!d[CB-1] && (d < CB'(len_r))) begin
              held_nxt  = '{st_r, note_r, vel_r, d[OFF_W-1:0], 1'b0, 1'b0};
              hv_nxt    = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              trig_nxt  = t;
              state_nxt = S_QUEUE;
            end
          end else begin
            li_nxt = li_r + LCW'(1);
          end
        end else begin
          held_nxt  = '{st_r, note_r, vel_r, off_r, 1'b0, 1'b0};
          hv_nxt    = 1'b1;
          state_nxt = S_FLUSH;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sc_r     <= '0;
      len_r    <= '0;
      lstart_r <= '0;
      lpps_r   <= '0;
      lhave_r  <= 1'b0;
      pcnt_r   <= '0;
      lcnt_r   <= '0;
      pi_r     <= '0;
      li_r     <= '0;
      n_r      <= '0;
      hv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sc_r     <= sc_nxt;
      len_r    <= len_nxt;
      lstart_r <= lstart_nxt;
      lpps_r   <= lpps_nxt;
      lhave_r  <= lhave_nxt;
      pcnt_r   <= pcnt_nxt;
      lcnt_r   <= lcnt_nxt;
      pi_r     <= pi_nxt;
      li_r     <= li_nxt;
      n_r      <= n_nxt;
      hv_r     <= hv_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    note_r <= note_nxt;
    vel_r  <= vel_nxt;
    off_r  <= off_nxt;
    p_r    <= p_nxt;
    trig_r <= trig_nxt;
    gap_r  <= gap_nxt;
    held_r <= held_nxt;
  end

  // Pending queue: removal closes the gap, append goes to the end.
  always_ff @(posedge clk) begin
    for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
      if (prm && (PCW'(j) >= prm_idx)) begin
        pmsg_r[j]  <= pmsg_r[j+1];
        ptrig_r[j] <= ptrig_r[j+1];
      end
    end
    if (papp) begin
      pmsg_r[pcnt_r[PIW-1:0]]  <= {st_r, note_r, vel_r};
      ptrig_r[pcnt_r[PIW-1:0]] <= papp_trig;
    end
  end

  // Placed table: same discipline.
  always_ff @(posedge clk) begin
    for (int j = 0; j < PLACED_DEPTH - 1; j++) begin
      if (lrm && (LCW'(j) >= lrm_idx)) begin
        lch_r[j]   <= lch_r[j+1];
        lnote_r[j] <= lnote_r[j+1];
        ltrig_r[j] <= ltrig_r[j+1];
      end
    end
    if (lapp) begin
      lch_r[lcnt_r[LIW-1:0]]   <= st_r[3:0];
      lnote_r[lcnt_r[LIW-1:0]] <= note_r;
      ltrig_r[lcnt_r[LIW-1:0]] <= lapp_trig;
    end
  end

endmodule
`default_nettype wire

// File: sv/midi_note_quantize_scheduler_unit.sv
// Top level of the MIDI note quantize scheduler: configuration registers,
// front end, back end and result queue. Depends on mnq_pkg and all mnq_ modules.
`default_nettype none
// Items enter through a two-beat input queue and are worked one at a time by
// the back-end sequencer; results leave through a four-beat result queue, the
// last result of an item flagged by out_last. A plain MIDI event or one that is
// not quantized is passed from the idle state through the flush state. A block
// start scans the pending queue and emits its due entries. A quantized note-on
// runs two divisions on the shared restoring divider. A quantized note-off
// forms the 10 ms gap with one multiply and then walks the pending queue and
// the placed table one entry per cycle. Results are in processing order, not
// sorted.
module midi_note_quantize_scheduler_unit #(
  parameter int PENDING_DEPTH = 32,
  parameter int PLACED_DEPTH  = 16,
  parameter int COUNTER_BITS  = 48
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire                          in_op,
  input  wire [12:0]                   in_block_size,
  input  wire [55:0]                   in_block_start_ppq,
  input  wire [32:0]                   in_ppq_per_sample,
  input  wire                          in_have_ppq,
  input  wire [11:0]                   in_event_offset,
  input  wire [7:0]                    in_status_byte,
  input  wire [6:0]                    in_note_number,
  input  wire [6:0]                    in_velocity,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [7:0]                   out_status,
  output logic [6:0]                   out_note,
  output logic [6:0]                   out_velocity,
  output logic [11:0]                  out_offset,
  output logic                         out_dropped,
  output logic                         out_last,
  input  wire                          cfg_wr_en,
  input  wire [1:0]                    cfg_index,
  input  wire [36:0]                   cfg_wdata
);
  import mnq_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  logic    item_valid, item_pop;
  logic    opush, ofull;
  result_t odata, rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid        <= '0;
      cfg_r.vel_fixed   <= 1'b0;
      cfg_r.vel_value   <= 7'd100;
      cfg_r.sample_rate <= SR_W'(48000);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID:        cfg_r.grid        <= cfg_wdata[GRID_W-1:0];
        REG_VEL_FIXED:   cfg_r.vel_fixed   <= cfg_wdata[0];
        REG_VEL_VALUE:   cfg_r.vel_value   <= cfg_wdata[6:0];
        REG_SAMPLE_RATE: cfg_r.sample_rate <= cfg_wdata[SR_W-1:0];
        default: ;
      endcase
    end
  end

  mnq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_op              (in_op),
    .in_block_size      (in_block_size),
    .in_block_start_ppq (in_block_start_ppq),
    .in_ppq_per_sample  (in_ppq_per_sample),
    .in_have_ppq        (in_have_ppq),
    .in_event_offset    (in_event_offset),
    .in_status_byte     (in_status_byte),
    .in_note_number     (in_note_number),
    .in_velocity        (in_velocity),
    .cfg                (cfg_r),
    .item               (item),
    .item_valid         (item_valid),
    .item_pop           (item_pop)
  );

  mnq_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .PLACED_DEPTH  (PLACED_DEPTH),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .opush      (opush),
    .odata      (odata),
    .ofull      (ofull)
  );

  mnq_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (opush),
    .wdata (odata),
    .full  (ofull),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (rdata)
  );

  assign out_status   = rdata.status;
  assign out_note     = rdata.note;
  assign out_velocity = rdata.vel;
  assign out_offset   = rdata.offset;
  assign out_dropped  = rdata.dropped;
  assign out_last     = rdata.last;

  // The back end never writes a beat into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(opush && ofull))
    else $error("result beat pushed into a full queue");

  // The back end only takes an item that the front end holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) item_pop |-> item_valid)
    else $error("item taken from an empty front queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the MIDI note quantize scheduler: a directed stimulus
// table, then random audio blocks with note traffic, all checked against a model.
// Depends on mnq_pkg and midi_note_quantize_scheduler_unit.
`timescale 1ns / 1ps
module testbench;
  import mnq_pkg::*;

  localparam logic OP_BLOCK = 1'b0;
  localparam logic OP_EVENT = 1'b1;
  localparam int HELD_DEPTH = 32;
  localparam int PLACE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] NOTE_ON0 = {ST_NOTE_ON, 4'h0};
  localparam logic [7:0] NOTE_OFF0 = {ST_NOTE_OFF, 4'h0};

  // One row of stimulus: either a register write or an input item.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [36:0] cfg_val;
    logic        op;
    logic [12:0] bs;
    logic [55:0] ppq;
    logic [32:0] pps;
    logic        have;
    logic [11:0] off;
    logic [7:0]  st;
    logic [6:0]  note;
    logic [6:0]  vel;
    bit          typed;
    logic [11:0] t_off;
    logic [6:0]  t_vel;
  } stim_t;

  typedef struct {
    logic [7:0]  st;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [47:0] trig;
  } held_t;

  typedef struct {
    logic [3:0]  ch;
    logic [6:0]  note;
    logic [47:0] trig;
  } placed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_op = 1'b0;
  logic [12:0] in_block_size = '0;
  logic [55:0] in_block_start_ppq = '0;
  logic [32:0] in_ppq_per_sample = '0;
  logic in_have_ppq = 1'b0;
  logic [11:0] in_event_offset = '0;
  logic [7:0] in_status_byte = '0;
  logic [6:0] in_note_number = '0;
  logic [6:0] in_velocity = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_status;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic [11:0] out_offset;
  logic out_dropped;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [36:0] cfg_wdata = '0;

  midi_note_quantize_scheduler_unit dut (.*);

  // Model state and register mirror.
  logic [36:0] grid_q = '0;
  logic        vfix_q = 1'b0;
  logic [6:0]  vval_q = 7'd100;
  logic [17:0] srate_q = 18'd48000;
  logic [47:0] smp_cnt = '0;
  logic [12:0] blk_len = '0;
  logic [55:0] lat_ppq = '0;
  logic [32:0] lat_pps = '0;
  logic        lat_have = 1'b0;
  held_t       held_q[$];
  placed_t     placed_q[$];
  result_t     step_beats[$];
  result_t     midi_out_q[$];

  int cycle = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int dropped_seen = 0;
  int items_sent = 0;
  int hold_left = 0;
  int rx_tick = 0;
  int rx_mode = 0;
  int burst_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("cycle %0d: %s got %0h want %0h", cycle, what, got, want);
    mismatches++;
  endtask

  // Compare each popped beat with the oldest predicted one.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_pop && !out_empty) begin
      beats_checked++;
      if (out_dropped) dropped_seen++;
      if (midi_out_q.size() == 0) begin
        report_mismatch("unexpected beat, status", out_status, 0);
      end else begin
        e = midi_out_q.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_note !== e.note) report_mismatch("note", out_note, e.note);
        if (out_velocity !== e.vel) report_mismatch("velocity", out_velocity, e.vel);
        if (out_offset !== e.offset) report_mismatch("offset", out_offset, e.offset);
        if (out_dropped !== e.dropped) report_mismatch("dropped", out_dropped, e.dropped);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Receiver: changing pop pattern, plus a long hold-off when requested.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 80 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      out_pop = 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0: out_pop = 1'b1;
        1: out_pop = 1'($urandom_range(0, 1));
        2: out_pop = ($urandom_range(0, 3) == 0);
        default: out_pop = (rx_tick % 16) < 12;
      endcase
    end
  end

  function automatic result_t beat(input logic [7:0] st, input logic [6:0] note,
                                   input logic [6:0] vel, input logic [11:0] off,
                                   input logic drop);
    result_t b;
    b.status = st;
    b.note = note;
    b.vel = vel;
    b.offset = off;
    b.dropped = drop;
    b.last = 1'b0;
    return b;
  endfunction

  function automatic bit note_on(input logic [7:0] st, input logic [6:0] vel);
    return st[7:4] == ST_NOTE_ON && vel != 0;
  endfunction

  function automatic bit note_off(input logic [7:0] st, input logic [6:0] vel);
    return st[7:4] == ST_NOTE_OFF || (st[7:4] == ST_NOTE_ON && vel == 0);
  endfunction

  // Later of two counter times, compared by their wrapped difference.
  function automatic logic [47:0] later(input logic [47:0] a, input logic [47:0] b);
    logic [47:0] d;
    d = b - a;
    return (d != 0 && !d[47]) ? b : a;
  endfunction

  // Queue an event for a later block, or flag it lost when the queue is full.
  task automatic park(input logic [7:0] st, input logic [6:0] note,
                      input logic [6:0] vel, input logic [47:0] trig);
    held_t h;
    if (held_q.size() >= HELD_DEPTH) begin
      step_beats = {step_beats, beat(st, note, vel, 12'd0, 1'b1)};
    end else begin
      h.st = st;
      h.note = note;
      h.vel = vel;
      h.trig = trig;
      held_q = {held_q, h};
    end
  endtask

  // Work out the beats that one accepted item causes and queue them.
  task automatic quantize_item(input stim_t s);
    logic [63:0] p, g, shift, target, off64, pps64, grid64;
    logic [47:0] trig, natural, d, gap;
    logic [12:0] bs;
    logic [11:0] off;
    logic [6:0] vel;
    logic [3:0] ch;
    placed_t pe;
    bit quant, handled;
    int i;
    step_beats.delete();
    if (s.op == OP_BLOCK) begin
      bs = (s.bs == 0) ? 13'd1 : (s.bs > MAX_BLOCK ? 13'(MAX_BLOCK) : s.bs);
      smp_cnt = smp_cnt + 48'(blk_len);
      blk_len = bs;
      lat_ppq = s.ppq;
      lat_pps = s.pps;
      lat_have = s.have;
      placed_q.delete();
      i = 0;
      while (i < held_q.size() && step_beats.size() < RESULT_CAP) begin
        d = held_q[i].trig - smp_cnt;
        if (d[47] || d < 48'(bs)) begin
          if (d[47]) d = 0;
          if (d > 48'(bs - 1)) d = 48'(bs - 1);
          step_beats = {step_beats, beat(held_q[i].st, held_q[i].note, held_q[i].vel,
                                         d[11:0], 1'b0)};
          held_q.delete(i);
        end else begin
          i++;
        end
      end
    end else begin
      off = s.off;
      vel = s.vel;
      ch = s.st[3:0];
      handled = 0;
      if (blk_len == 0) off = 0;
      else if (13'(off) >= blk_len) off = 12'(blk_len - 1);
      if (vfix_q && note_on(s.st, vel)) vel = (vval_q == 0) ? 7'd1 : vval_q;
      quant = grid_q != 0 && lat_have && lat_pps != 0;
      if (quant && note_on(s.st, vel)) begin
        off64 = 64'(off);
        pps64 = 64'(lat_pps);
        grid64 = 64'(grid_q);
        p = 64'(lat_ppq) + off64 * pps64;
        g = ((p + grid64 - 1) / grid64) * grid64;
        shift = (2 * (g - p) + pps64) / (2 * pps64);
        target = off64 + shift;
        if (target < 64'(blk_len)) begin
          step_beats = {step_beats, beat(s.st, s.note, vel, target[11:0], 1'b0)};
          if (placed_q.size() < PLACE_DEPTH) begin
            pe.ch = ch;
            pe.note = s.note;
            pe.trig = smp_cnt + target[47:0];
            placed_q = {placed_q, pe};
          end
        end else begin
          park(s.st, s.note, vel, smp_cnt + target[47:0]);
        end
        handled = 1;
      end else if (quant && note_off(s.st, vel)) begin
        gap = 48'(srate_q / GAP_DIV);
        natural = smp_cnt + 48'(off);
        for (i = 0; i < held_q.size() && !handled; i++) begin
          if (note_on(held_q[i].st, held_q[i].vel) && held_q[i].st[3:0] == ch &&
              held_q[i].note == s.note) begin
            park(s.st, s.note, vel, later(natural, held_q[i].trig + gap));
            handled = 1;
          end
        end
        for (i = 0; i < placed_q.size() && !handled; i++) begin
          if (placed_q[i].ch == ch && placed_q[i].note == s.note) begin
            trig = later(natural, placed_q[i].trig + gap);
            d = trig - smp_cnt;
            if (!d[47] && d < 48'(blk_len))
              step_beats = {step_beats, beat(s.st, s.note, vel, d[11:0], 1'b0)};
            else
              park(s.st, s.note, vel, trig);
            placed_q.delete(i);
            handled = 1;
          end
        end
      end
      if (!handled) step_beats = {step_beats, beat(s.st, s.note, vel, off, 1'b0)};
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[k]) midi_out_q = {midi_out_q, step_beats[k]};
  endtask

  // Offer one item in bursts with random gaps, then predict once it is taken.
  task automatic offer(input stim_t s);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap_len) begin
        @(negedge clk);
        in_push = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_op = s.op;
    in_block_size = s.bs;
    in_block_start_ppq = s.ppq;
    in_ppq_per_sample = s.pps;
    in_have_ppq = s.have;
    in_event_offset = s.off;
    in_status_byte = s.st;
    in_note_number = s.note;
    in_velocity = s.vel;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    quantize_item(s);
    if (s.typed)
      midi_out_q[midi_out_q.size() - 1] = '{s.st, s.note, s.t_vel, s.t_off, 1'b0, 1'b1};
    items_sent++;
  endtask

  // Stop offering and wait until every predicted beat has come and work is done.
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (midi_out_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [36:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_GRID:        grid_q = val;
      REG_VEL_FIXED:   vfix_q = val[0];
      REG_VEL_VALUE:   vval_q = val[6:0];
      REG_SAMPLE_RATE: srate_q = val[17:0];
      default: ;
    endcase
  endtask

  function automatic stim_t row_cfg(input logic [1:0] idx, input logic [36:0] val);
    stim_t s = '{default: 0};
    s.is_cfg = 1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic stim_t row_blk(input logic [12:0] bs, input logic [55:0] ppq,
                                    input logic [32:0] pps, input logic have);
    stim_t s = '{default: 0};
    s.op = OP_BLOCK;
    s.bs = bs;
    s.ppq = ppq;
    s.pps = pps;
    s.have = have;
    return s;
  endfunction

  function automatic stim_t row_evt(input logic [11:0] off, input logic [7:0] st,
                                    input logic [6:0] note, input logic [6:0] vel);
    stim_t s = '{default: 0};
    s.op = OP_EVENT;
    s.off = off;
    s.st = st;
    s.note = note;
    s.vel = vel;
    return s;
  endfunction

  function automatic stim_t row_typed(input stim_t s, input logic [11:0] t_off,
                                      input logic [6:0] t_vel);
    s.typed = 1;
    s.t_off = t_off;
    s.t_vel = t_vel;
    return s;
  endfunction

  // Random blocks, each a block start followed by a few events on a small
  // set of notes so that note-offs find their note-ons.
  task automatic random_blocks(input int n_items, input logic [32:0] pps_now);
    int done, k, r;
    logic [55:0] song_ppq;
    logic [12:0] bs, eff;
    stim_t s;
    done = 0;
    song_ppq = 56'({$urandom, $urandom});
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) bs = 13'($urandom_range(16, 300));
      else if (r < 85) bs = 0;
      else if (r < 90) bs = 13'(MAX_BLOCK);
      else if (r < 95) bs = 13'($urandom);
      else bs = 13'($urandom_range(1, 15));
      s = row_blk(bs, song_ppq, pps_now, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) == 0) s.ppq = 56'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) s.pps = 33'({$urandom, $urandom});
      offer(s);
      done++;
      eff = (bs == 0) ? 13'd1 : (bs > MAX_BLOCK ? 13'(MAX_BLOCK) : bs);
      song_ppq = song_ppq + 56'(eff) * 56'(pps_now);
      k = $urandom_range(0, 6);
      repeat (k) begin
        s = row_evt(12'($urandom_range(0, eff - 1)), 8'h00,
                    7'(60 + $urandom_range(0, 3)), 7'($urandom_range(1, 127)));
        if ($urandom_range(0, 9) == 0) s.off = 12'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45) begin
          s.st = {ST_NOTE_ON, 4'($urandom_range(0, 1))};
        end else if (r < 80) begin
          s.st = {ST_NOTE_OFF, 4'($urandom_range(0, 1))};
          if ($urandom_range(0, 1)) begin
            s.st[7:4] = ST_NOTE_ON;
            s.vel = 0;
          end
        end else if (r < 90) begin
          s.st = {4'($urandom_range(10, 15)), 4'($urandom)};
        end else begin
          s.st = 8'($urandom);
          s.note = 7'($urandom);
          s.vel = 7'($urandom);
        end
        offer(s);
        done++;
      end
    end
  endtask

  initial begin
    stim_t plan[$];
    int ph;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Defaults: no quantizing, clamping of offsets and block sizes.
    plan = {plan, row_typed(row_evt(12'hFFF, NOTE_ON0, 7'h7F, 7'h7F), 12'd0, 7'h7F)};
    plan = {plan, row_blk(13'd0, '1, '1, 1'b1)};
    plan = {plan, row_typed(row_evt(12'hFFF, NOTE_OFF0, 7'd0, 7'd0), 12'd0, 7'd0)};
    plan = {plan, row_blk(13'h1FFF, '0, '0, 1'b0)};
    plan = {plan, row_typed(row_evt(12'hFFF, 8'hFF, 7'h7F, 7'h7F), 12'hFFF, 7'h7F)};
    plan = {plan, row_typed(row_evt(12'd0, 8'h00, 7'd0, 7'd0), 12'd0, 7'd0)};
    // Fixed velocity of zero is raised to one; a zero-velocity note-on is left alone.
    plan = {plan, row_cfg(REG_VEL_FIXED, 37'd1)};
    plan = {plan, row_cfg(REG_VEL_VALUE, 37'd0)};
    plan = {plan, row_typed(row_evt(12'd7, 8'h93, 7'd5, 7'd9), 12'd7, 7'd1)};
    plan = {plan, row_typed(row_evt(12'd7, 8'h93, 7'd5, 7'd0), 12'd7, 7'd0)};
    // Grid of 256 samples: queued note-on with held note-off, placed pair.
    plan = {plan, row_cfg(REG_GRID, 37'h0040000000)};
    plan = {plan, row_cfg(REG_SAMPLE_RATE, 37'd8000)};
    plan = {plan, row_cfg(REG_VEL_VALUE, 37'd127)};
    plan = {plan, row_blk(13'd256, 56'd0, 33'h000400000, 1'b1)};
    plan = {plan, row_evt(12'd10, NOTE_ON0, 7'd60, 7'd50)};
    plan = {plan, row_evt(12'd20, NOTE_OFF0, 7'd60, 7'd64)};
    plan = {plan, row_evt(12'd0, 8'h91, 7'd61, 7'd1)};
    plan = {plan, row_evt(12'd5, 8'h81, 7'd61, 7'd0)};
    plan = {plan, row_evt(12'd30, 8'h92, 7'd62, 7'd0)};
    plan = {plan, row_blk(13'd512, 56'h40000000, 33'h000400000, 1'b1)};
    plan = {plan, row_evt(12'd100, NOTE_ON0, 7'd70, 7'd3)};
    plan = {plan, row_blk(13'd64, 56'd0, 33'h000400000, 1'b0)};
    plan = {plan, row_evt(12'd3, NOTE_OFF0, 7'd70, 7'd0)};
    // Largest grid and sample rate: the note-on lands far in the future.
    plan = {plan, row_cfg(REG_GRID, 37'h1FFFFFFFFF)};
    plan = {plan, row_cfg(REG_SAMPLE_RATE, 37'h3FFFF)};
    plan = {plan, row_cfg(REG_VEL_FIXED, 37'd0)};
    plan = {plan, row_blk(13'd4096, 56'd0, 33'd1, 1'b1)};
    plan = {plan, row_evt(12'd5, 8'h9F, 7'h7F, 7'h7F)};
    plan = {plan, row_evt(12'd6, 8'h8F, 7'h7F, 7'd1)};

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        offer(plan[i]);
      end
    end

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_GRID, 37'h0040000000);
          write_reg(REG_SAMPLE_RATE, 37'd48000);
        end
        1: begin
          write_reg(REG_GRID, 37'h0010000000);
          write_reg(REG_SAMPLE_RATE, 37'd192000);
          write_reg(REG_VEL_FIXED, 37'd1);
          write_reg(REG_VEL_VALUE, 37'($urandom_range(1, 127)));
        end
        2: begin
          write_reg(REG_GRID, {5'($urandom), $urandom});
          write_reg(REG_SAMPLE_RATE, 37'($urandom_range(0, 262143)));
          write_reg(REG_VEL_FIXED, 37'd0);
        end
        3: begin
          write_reg(REG_GRID, 37'h1000000000);
          write_reg(REG_SAMPLE_RATE, 37'd8000);
        end
        default: begin
          write_reg(REG_GRID, 37'h0020000000);
          write_reg(REG_SAMPLE_RATE, 37'd44100);
          hold_left = 600;
        end
      endcase
      case (ph)
        2: random_blocks(25, {1'($urandom_range(0, 1)), $urandom});
        3: random_blocks(25, 33'h004000000);
        default: random_blocks(25, 33'h000400000);
      endcase
    end

    settle();
    $display("sent %0d items over defaults, fixed velocity and five grid settings",
             items_sent);
    $display("checked %0d result beats, %0d of them flagged as dropped",
             beats_checked, dropped_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
